// ----- hdl/ppte_pkg.sv -----
// ----------------------------------------------------------------------------
// ppte_pkg
// Shared types, command codes and fixed-point helpers for the trajectory
// evaluator.
// ----------------------------------------------------------------------------
package ppte_pkg;

  typedef logic signed [63:0] q32_t;  // Q32.32 accumulator / coefficient
  typedef logic signed [47:0] q24_t;  // Q24.24 result

  // segment capacity; RAM depths follow it, the segment and boundary index port widths are fixed
  localparam int MAX_SEGMENTS = 16;

  localparam logic [1:0] KIND_COEF  = 2'd0;
  localparam logic [1:0] KIND_BOUND = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  localparam logic [1:0] CFG_SEG_COUNT = 2'd0;
  localparam logic [1:0] CFG_END_X     = 2'd1;
  localparam logic [1:0] CFG_END_Y     = 2'd2;
  localparam logic [1:0] CFG_END_Z     = 2'd3;

  localparam logic [1:0] CH_POS = 2'd0;
  localparam logic [1:0] CH_VEL = 2'd1;

  // Horner weight for channel ch (pos, vel, acc) at coefficient slot.
  function automatic logic [5:0] horner_weight(logic [1:0] ch, logic [2:0] slot);
    logic [5:0] w;
    w = 6'd0;
    if (ch == CH_POS) begin
      w = 6'd1;
    end else if (ch == CH_VEL) begin
      w = 6'd7 - {3'd0, slot};
    end else begin
      case (slot)
        3'd0:    w = 6'd42;
        3'd1:    w = 6'd30;
        3'd2:    w = 6'd20;
        3'd3:    w = 6'd12;
        3'd4:    w = 6'd6;
        3'd5:    w = 6'd2;
        default: w = 6'd0;
      endcase
    end
    return w;
  endfunction

  // Saturating signed 64-bit add.
  function automatic q32_t sat_add64(q32_t a, q32_t b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  // Q32.32 to Q24.24, round half away from zero, saturate to 48 bits.
  function automatic q24_t to_q24(q32_t v);
    logic [63:0] mag;
    logic [64:0] sum;
    logic [56:0] r;
    mag = v[63] ? (64'd0 - v) : v;
    sum = {1'b0, mag} + 65'd128;
    r   = sum[64:8];
    if (v[63]) begin
      if (r > 57'h800000000000) r = 57'h800000000000;
      return 48'd0 - r[47:0];
    end
    if (r > 57'h7FFFFFFFFFFF) r = 57'h7FFFFFFFFFFF;
    return r[47:0];
  endfunction

endpackage

// ----- hdl/ppte_ram.sv -----
// ----------------------------------------------------------------------------
// ppte_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module ppte_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- hdl/piecewise_poly_trajectory_eval.sv -----
// ----------------------------------------------------------------------------
// piecewise_poly_trajectory_eval
// Piecewise 7th-order polynomial trajectory evaluator: position, velocity and
// acceleration of x/y/z at a query time, from coefficient and boundary RAMs.
// ----------------------------------------------------------------------------
// Sequence: loads finish in the accept cycle. A query past the final boundary
//   strobes done_o after the S_BCHK compare; otherwise after a boundary
//   scan of one RAM read per cycle over the n segments in use, then 3 axes
//   x 8 coefficient reads, each feeding up to three Horner steps on one
//   shared 32x32 multiplier (two passes per 64x32 product).
// Throughput: one transaction at a time; busy is high until done_o.
// Reset: async active low; config returns to segment_count 1 and zero end
//   waypoint. RAM contents are undefined until loaded. Results cannot stall.
module piecewise_poly_trajectory_eval (
  input  logic              clk_i,
  input  logic              rst_ni,
  // command channel
  input  logic              start,
  output logic              busy,
  output logic              done_o,
  input  logic [1:0]        kind_i,
  input  logic [3:0]        segment_i,
  input  logic [1:0]        axis_i,
  input  logic [2:0]        power_slot_i,
  input  logic [4:0]        boundary_index_i,
  input  ppte_pkg::q32_t    coef_value_i,
  input  logic [31:0]       time_value_i,
  // configuration write port
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [47:0]       cfg_wdata_i,
  // results
  output ppte_pkg::q24_t    pos_x_o,
  output ppte_pkg::q24_t    pos_y_o,
  output ppte_pkg::q24_t    pos_z_o,
  output ppte_pkg::q24_t    vel_x_o,
  output ppte_pkg::q24_t    vel_y_o,
  output ppte_pkg::q24_t    vel_z_o,
  output ppte_pkg::q24_t    acc_x_o,
  output ppte_pkg::q24_t    acc_y_o,
  output ppte_pkg::q24_t    acc_z_o,
  output logic [3:0]        segment_used_o,
  output logic              past_end_o
);
  import ppte_pkg::*;

  localparam int BDEPTH = MAX_SEGMENTS + 1;
  localparam int BW     = $clog2(BDEPTH);          // boundary index / count
  localparam int CDEPTH = MAX_SEGMENTS * 24;
  localparam int CAW    = $clog2(CDEPTH);

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_BCHK = 4'd1;   // final boundary compare
  localparam logic [3:0] S_SCAN = 4'd2;   // count boundaries <= t
  localparam logic [3:0] S_CRD  = 4'd3;   // issue coefficient read
  localparam logic [3:0] S_CWT  = 4'd4;   // capture coefficient
  localparam logic [3:0] S_WGT  = 4'd5;   // weighted coef, accumulator magnitude
  localparam logic [3:0] S_INIT = 4'd6;   // first Horner term
  localparam logic [3:0] S_MLO  = 4'd7;   // low half product
  localparam logic [3:0] S_MHI  = 4'd8;   // high half product
  localparam logic [3:0] S_COMB = 4'd9;   // round, shift, saturate
  localparam logic [3:0] S_ADD  = 4'd10;  // add weighted coefficient
  localparam logic [3:0] S_CONV = 4'd11;  // Q24.24 conversion for one axis

  logic [3:0]    state_q, state_d;

  // configuration
  logic [4:0]    seg_count_q;
  q24_t          end_q [3];

  // query context
  logic [31:0]   t_q;
  logic [BW-1:0] idx_q, idx_d, cnt_q, cnt_d, k_q, k_d;
  logic          scan_vld_q, scan_vld_d;
  logic [1:0]    axis_q, axis_d, ch_q, ch_d;
  logic [2:0]    slot_q, slot_d;

  // datapath
  q32_t          c_q, wc_q, mt_q;
  logic [63:0]   mag_q;
  logic          neg_q;
  logic [63:0]   plo_q, phi_q;
  q32_t          hacc_q [3];
  q24_t          res_q [9];
  logic [3:0]    seg_used_q;
  logic          past_end_q;
  logic          done_q;

  // ---------------------------------------------------------------------------
  // segments in use, clamped to 1..MAX_SEGMENTS
  // ---------------------------------------------------------------------------
  logic [BW-1:0] n_w;
  always_comb begin
    if (seg_count_q == 5'd0) begin
      n_w = BW'(1);
    end else if (32'(seg_count_q) > 32'(MAX_SEGMENTS)) begin
      n_w = BW'(MAX_SEGMENTS);
    end else begin
      n_w = BW'(seg_count_q);
    end
  end

  logic accept;
  assign accept = start && !busy;

  // ---------------------------------------------------------------------------
  // RAMs
  // ---------------------------------------------------------------------------
  logic           b_we, b_re;
  logic [BW-1:0]  b_raddr;
  logic [31:0]    b_rdata;
  logic           c_we, c_re;
  logic [CAW-1:0] c_waddr, c_raddr;
  q32_t           c_rdata;

  assign b_we = accept && (kind_i == KIND_BOUND) &&
                (32'(boundary_index_i) <= 32'(MAX_SEGMENTS));
  assign c_we = accept && (kind_i == KIND_COEF) &&
                (32'(segment_i) < 32'(MAX_SEGMENTS)) && (axis_i != 2'd3);
  assign c_waddr = CAW'((32'(segment_i) * 32'd3 + 32'(axis_i)) * 32'd8 +
                        32'(power_slot_i));
  assign c_raddr = CAW'((32'(k_q) * 32'd3 + 32'(axis_q)) * 32'd8 + 32'(slot_q));
  assign c_re    = (state_q == S_CRD);

  always_comb begin
    b_re    = 1'b0;
    b_raddr = idx_q;
    if (accept && kind_i == KIND_QUERY) begin
      b_re    = 1'b1;
      b_raddr = n_w;
    end else if (state_q == S_SCAN && idx_q != n_w) begin
      b_re    = 1'b1;
    end
  end

  ppte_ram #(.WIDTH(32), .DEPTH(BDEPTH)) u_bound_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (boundary_index_i[BW-1:0]),
    .wdata_i (time_value_i),
    .re_i    (b_re),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  ppte_ram #(.WIDTH(64), .DEPTH(CDEPTH)) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (coef_value_i),
    .re_i    (c_re),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  // ---------------------------------------------------------------------------
  // arithmetic
  // ---------------------------------------------------------------------------
  // weighted coefficient, saturated to 64 bits
  logic signed [70:0] wprod;
  q32_t               wc_d;
  assign wprod = c_q * $signed({1'b0, horner_weight(ch_q, slot_q)});
  always_comb begin
    if (wprod[70:63] != {8{wprod[63]}}) begin
      wc_d = wprod[70] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      wc_d = wprod[63:0];
    end
  end

  // shared 32x32 multiplier: low half, then high half of |acc|
  logic [31:0] mop;
  logic [63:0] mprod;
  assign mop   = (state_q == S_MLO) ? mag_q[31:0] : mag_q[63:32];
  assign mprod = mop * t_q;

  // (|acc| * t + 2^19) >> 20, saturated, sign restored
  logic [95:0] sum96;
  q32_t        mt_d;
  assign sum96 = {phi_q, 32'd0} + {32'd0, plo_q} + 96'd524288;
  always_comb begin
    if (sum96[95:83] != '0) begin
      mt_d = neg_q ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      mt_d = neg_q ? (64'd0 - {1'b0, sum96[82:20]}) : {1'b0, sum96[82:20]};
    end
  end

  // channel active at this slot: pos to slot 7, vel to 6, acc to 5
  logic ch_active;
  assign ch_active = (4'(slot_q) + 4'(ch_q)) <= 4'd7;

  // scan hit and final count
  logic          hit;
  logic [BW-1:0] cnt_fin;
  assign hit     = scan_vld_q && (b_rdata <= t_q);
  assign cnt_fin = cnt_q + BW'(hit);

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  logic res_end, res_conv, acc_init, acc_add;

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    k_d        = k_q;
    scan_vld_d = 1'b0;
    axis_d     = axis_q;
    ch_d       = ch_q;
    slot_d     = slot_q;
    res_end    = 1'b0;
    res_conv   = 1'b0;
    acc_init   = 1'b0;
    acc_add    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept && kind_i == KIND_QUERY) state_d = S_BCHK;
      end
      S_BCHK: begin
        if (t_q >= b_rdata) begin
          res_end = 1'b1;
          state_d = S_IDLE;
        end else begin
          idx_d   = '0;
          cnt_d   = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cnt_d = cnt_fin;
        if (idx_q != n_w) begin
          idx_d      = idx_q + BW'(1);
          scan_vld_d = 1'b1;
        end else begin
          k_d     = (cnt_fin == '0) ? '0 : cnt_fin - BW'(1);
          axis_d  = 2'd0;
          slot_d  = 3'd0;
          state_d = S_CRD;
        end
      end
      S_CRD: state_d = S_CWT;
      S_CWT: begin
        ch_d    = 2'd0;
        state_d = S_WGT;
      end
      S_WGT: begin
        if (ch_active) begin
          state_d = (slot_q == 3'd0) ? S_INIT : S_MLO;
        end else if (ch_q == 2'd2) begin
          // acc is done at this slot; move on unless the constant term is done
          if (slot_q == 3'd7) begin
            state_d = S_CONV;
          end else begin
            slot_d  = slot_q + 3'd1;
            state_d = S_CRD;
          end
        end else begin
          ch_d = ch_q + 2'd1;
        end
      end
      S_MLO:  state_d = S_MHI;
      S_MHI:  state_d = S_COMB;
      S_COMB: state_d = S_ADD;
      S_INIT, S_ADD: begin
        acc_init = (state_q == S_INIT);
        acc_add  = (state_q == S_ADD);
        if (ch_q != 2'd2) begin
          ch_d    = ch_q + 2'd1;
          state_d = S_WGT;
        end else if (slot_q == 3'd7) begin
          state_d = S_CONV;
        end else begin
          slot_d  = slot_q + 3'd1;
          state_d = S_CRD;
        end
      end
      S_CONV: begin
        res_conv = 1'b1;
        if (axis_q == 2'd2) begin
          state_d = S_IDLE;
        end else begin
          axis_d  = axis_q + 2'd1;
          slot_d  = 3'd0;
          state_d = S_CRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      done_q      <= 1'b0;
      scan_vld_q  <= 1'b0;
      seg_count_q <= 5'd1;
      end_q[0]    <= '0;
      end_q[1]    <= '0;
      end_q[2]    <= '0;
    end else begin
      state_q    <= state_d;
      scan_vld_q <= scan_vld_d;
      done_q     <= res_end || (res_conv && axis_q == 2'd2);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SEG_COUNT: seg_count_q <= cfg_wdata_i[4:0];
          CFG_END_X:     end_q[0]    <= cfg_wdata_i;
          CFG_END_Y:     end_q[1]    <= cfg_wdata_i;
          CFG_END_Z:     end_q[2]    <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    cnt_q  <= cnt_d;
    k_q    <= k_d;
    axis_q <= axis_d;
    ch_q   <= ch_d;
    slot_q <= slot_d;
    if (accept) t_q <= time_value_i;
    if (state_q == S_CWT) c_q <= c_rdata;
    if (state_q == S_WGT) begin
      wc_q  <= wc_d;
      neg_q <= hacc_q[ch_q][63];
      mag_q <= hacc_q[ch_q][63] ? (64'd0 - hacc_q[ch_q]) : hacc_q[ch_q];
    end
    if (state_q == S_MLO)  plo_q <= mprod;
    if (state_q == S_MHI)  phi_q <= mprod;
    if (state_q == S_COMB) mt_q  <= mt_d;
    if (acc_init) hacc_q[ch_q] <= wc_q;
    if (acc_add)  hacc_q[ch_q] <= sat_add64(mt_q, wc_q);
    if (res_end) begin
      res_q[0]   <= end_q[0];
      res_q[1]   <= end_q[1];
      res_q[2]   <= end_q[2];
      for (int i = 3; i < 9; i++) res_q[i] <= '0;
      seg_used_q <= 4'd0;
      past_end_q <= 1'b1;
    end
    if (res_conv) begin
      res_q[axis_q]            <= to_q24(hacc_q[0]);
      res_q[4'(axis_q) + 4'd3] <= to_q24(hacc_q[1]);
      res_q[4'(axis_q) + 4'd6] <= to_q24(hacc_q[2]);
      seg_used_q               <= 4'(k_q);
      past_end_q               <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // outputs
  // ---------------------------------------------------------------------------
  assign busy           = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign pos_x_o        = res_q[0];
  assign pos_y_o        = res_q[1];
  assign pos_z_o        = res_q[2];
  assign vel_x_o        = res_q[3];
  assign vel_y_o        = res_q[4];
  assign vel_z_o        = res_q[5];
  assign acc_x_o        = res_q[6];
  assign acc_y_o        = res_q[7];
  assign acc_z_o        = res_q[8];
  assign segment_used_o = seg_used_q;
  assign past_end_o     = past_end_q;

endmodule
